### rtl/core/mdbfc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the nine-bit bus frame capture block.
// No dependencies; used by mdbfc_ctrl, the top level and mdbfc_checker.
package mdbfc_pkg;

  localparam int BUF_DEPTH_DEF = 64;
  localparam int WORD_W        = 9;
  localparam int BYTE_W        = 8;
  localparam int TICK_W        = 16;
  localparam int MODE_BIT      = 8;
  localparam int CFG_AW        = 3;
  localparam int CFG_DW        = 32;

  localparam logic [WORD_W-1:0] WATCH_RESET   = 9'd272;
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd1000;

  // Register index, taken from paddr[2].
  localparam logic REG_WATCH   = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  localparam logic ACT_WORD = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_BYTE  = 2'd0,
    ST_CKSUM = 2'd1,
    ST_OVF   = 2'd2
  } status_t;

  typedef struct packed {
    logic              action;
    logic [WORD_W-1:0] bus_word;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [BYTE_W-1:0] frame_byte;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] watch_address;
    logic [TICK_W-1:0] timeout_ticks;
  } cfg_t;

endpackage

### rtl/core/mdbfc_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module mdbfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/mdbfc_ctrl.sv
`timescale 1ns / 1ps
// Frame sequencer: word/tick handling, frame store, the checksum byte adder and
// the store walks for the checksum and emit pass. Uses mdbfc_pkg, mdbfc_ram.
module mdbfc_ctrl #(
  parameter int BUF_DEPTH = mdbfc_pkg::BUF_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mdbfc_pkg::cfg_t      cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mdbfc_pkg::in_item_t  in_data,
  input  logic                 slot_free,
  output logic                 res_load,
  output mdbfc_pkg::out_item_t res_data
);

  import mdbfc_pkg::*;

  localparam int AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int CNT_W = $clog2(BUF_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM_RD,
    S_SUM_ACC,
    S_EMIT_RD,
    S_EMIT_WR,
    S_ERR,
    S_OVF
  } state_t;

  state_t             state_r, state_nxt;
  logic               collecting_r, collecting_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [TICK_W-1:0]  ticks_r, ticks_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic [BYTE_W-1:0]  sum_r, sum_nxt;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [BYTE_W-1:0]  ram_rdata;
  logic [TICK_W-1:0]  ticks_inc;
  logic [CNT_W-1:0]   last_idx;
  logic               idx_is_last;
  logic               addr_match;

  mdbfc_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUF_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data.bus_word[BYTE_W-1:0]),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  assign ticks_inc   = (ticks_r == '1) ? ticks_r : ticks_r + TICK_W'(1);
  assign last_idx    = count_r - CNT_W'(1);
  assign idx_is_last = (CNT_W'(idx_r) == last_idx);
  assign addr_match  = (in_data.bus_word == cfg.watch_address);

  always_comb begin
    state_nxt      = state_r;
    collecting_nxt = collecting_r;
    count_nxt      = count_r;
    ticks_nxt      = ticks_r;
    idx_nxt        = idx_r;
    sum_nxt        = sum_r;
    in_ready       = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    res_load       = 1'b0;
    res_data       = '{status: ST_BYTE, frame_byte: '0, last: 1'b1};

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_data.action == ACT_TICK) begin
            if (collecting_r) begin
              ticks_nxt = ticks_inc;
              if (ticks_inc >= cfg.timeout_ticks) begin
                ticks_nxt = '0;
                idx_nxt   = '0;
                sum_nxt   = '0;
                state_nxt = S_SUM_RD;
              end
            end
          end else if (!collecting_r) begin
            if (addr_match) begin
              ram_we         = 1'b1;
              collecting_nxt = 1'b1;
              count_nxt      = CNT_W'(1);
              ticks_nxt      = '0;
            end
          end else if (count_r >= CNT_W'(BUF_DEPTH)) begin
            // Frame is dropped; the same word may open a new frame.
            ram_we         = addr_match;
            collecting_nxt = addr_match;
            count_nxt      = addr_match ? CNT_W'(1) : '0;
            ticks_nxt      = '0;
            state_nxt      = S_OVF;
          end else if (in_data.bus_word[MODE_BIT]) begin
            idx_nxt   = '0;
            sum_nxt   = '0;
            state_nxt = S_SUM_RD;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = count_r[AW-1:0];
            count_nxt = count_r + CNT_W'(1);
            ticks_nxt = '0;
          end
        end
      end

      S_SUM_RD: begin
        state_nxt = S_SUM_ACC;
      end

      S_SUM_ACC: begin
        if (idx_is_last) begin
          idx_nxt   = '0;
          state_nxt = (sum_r == ram_rdata) ? S_EMIT_RD : S_ERR;
        end else begin
          sum_nxt   = sum_r + ram_rdata;
          idx_nxt   = idx_r + AW'(1);
          state_nxt = S_SUM_RD;
        end
      end

      S_EMIT_RD: begin
        state_nxt = S_EMIT_WR;
      end

      S_EMIT_WR: begin
        if (slot_free) begin
          res_load = 1'b1;
          res_data = '{status: ST_BYTE, frame_byte: ram_rdata, last: idx_is_last};
          if (idx_is_last) begin
            collecting_nxt = 1'b0;
            count_nxt      = '0;
            ticks_nxt      = '0;
            state_nxt      = S_IDLE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = S_EMIT_RD;
          end
        end
      end

      S_ERR: begin
        if (slot_free) begin
          res_load       = 1'b1;
          res_data       = '{status: ST_CKSUM, frame_byte: '0, last: 1'b1};
          collecting_nxt = 1'b0;
          count_nxt      = '0;
          ticks_nxt      = '0;
          state_nxt      = S_IDLE;
        end
      end

      S_OVF: begin
        if (slot_free) begin
          res_load  = 1'b1;
          res_data  = '{status: ST_OVF, frame_byte: '0, last: 1'b1};
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      collecting_r <= 1'b0;
      count_r      <= '0;
      ticks_r      <= '0;
      idx_r        <= '0;
      sum_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      collecting_r <= collecting_nxt;
      count_r      <= count_nxt;
      ticks_r      <= ticks_nxt;
      idx_r        <= idx_nxt;
      sum_r        <= sum_nxt;
    end
  end

endmodule

### rtl/core/nine_bit_bus_frame_capture.sv
`timescale 1ns / 1ps
// Top level of the nine-bit bus frame capture block: register port, output
// register and the frame sequencer. Uses mdbfc_pkg and mdbfc_ctrl.
//
// Usage:
//   The input channel (in_valid/in_ready/in_data) carries one item per bus
//   event: either a received nine-bit word or one timer tick. The result
//   channel (out_valid/out_ready/out_data) carries frame bytes, a checksum
//   error or a buffer overflow, with last set on the final result of an item.
//   The register port holds watch_address at byte address 0 and
//   timeout_ticks at byte address 4; write them only while the block is idle.
// Timing:
//   An item that causes no result is taken while the block is idle, and the
//   block stays idle and ready for the next item. An overflow passes through
//   a further state that issues the overflow result. A frame close walks
//   the frame store twice through its single registered read port: a read
//   and an accumulate step per byte to form and check the sum, then a read
//   and a write step per emitted byte. in_ready stays low for the whole walk.
// Reset and stalls:
//   Reset returns the block to idle with both registers at their reset
//   values and no result pending. When the receiver stalls, the pending
//   result waits in the output register; the sequencer holds any next result.
module nine_bit_bus_frame_capture #(
  parameter int BUF_DEPTH = mdbfc_pkg::BUF_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  mdbfc_pkg::in_item_t             in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output mdbfc_pkg::out_item_t            out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mdbfc_pkg::CFG_AW-1:0]    paddr,
  input  logic [mdbfc_pkg::CFG_DW-1:0]    pwdata,
  output logic [mdbfc_pkg::CFG_DW-1:0]    prdata,
  output logic                            pready
);

  import mdbfc_pkg::*;

  cfg_t      cfg_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  logic      slot_free;
  logic      res_load;
  out_item_t res_data;
  logic      reg_idx;
  logic      cfg_wr;

  // Registers sit on 4-byte boundaries; bit 2 selects which one.
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    case (reg_idx)
      REG_WATCH:   prdata = CFG_DW'(cfg_r.watch_address);
      REG_TIMEOUT: prdata = CFG_DW'(cfg_r.timeout_ticks);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.watch_address <= WATCH_RESET;
      cfg_r.timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_WATCH:   cfg_r.watch_address <= pwdata[WORD_W-1:0];
        REG_TIMEOUT: cfg_r.timeout_ticks <= pwdata[TICK_W-1:0];
        default:     cfg_r <= cfg_r;
      endcase
    end
  end

  // The output register frees up in the same cycle its result is taken, so
  // a steady receiver sees no bubble from it.
  assign slot_free = !out_valid_r || out_ready;

  mdbfc_ctrl #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .slot_free (slot_free),
    .res_load  (res_load),
    .res_data  (res_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/core/mdbfc_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the nine-bit bus frame capture block, bound to the top.
// Uses mdbfc_pkg.
module mdbfc_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input mdbfc_pkg::out_item_t out_data
);

  import mdbfc_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Error and overflow results are single, closing and carry no byte.
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_CKSUM || out_data.status == ST_OVF)
      |-> out_data.last && (out_data.frame_byte == '0))
    else $error("error result malformed");

  // Only defined status codes appear.
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_BYTE || out_data.status == ST_CKSUM ||
                   out_data.status == ST_OVF))
    else $error("undefined status code");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind nine_bit_bus_frame_capture mdbfc_checker u_mdbfc_checker (.*);
